>>> sv/jomm_pkg.sv
// ----------------------------------------------------------------------------
// jomm_pkg
// Types, constants and arithmetic helpers shared by the joystick motor mixer.
// ----------------------------------------------------------------------------
package jomm_pkg;

	// Fixed-point precision of the 45 degree rotation coefficient.
	localparam int unsigned FRACTION_BITS = 16;

	// round(sqrt(1/2) * 2^FRACTION_BITS), derived from a Q32 value.
	localparam logic [63:0] SQRT_HALF_Q32 = 64'd3037000500;
	localparam logic [63:0] ROT_COEF_FULL =
		(SQRT_HALF_Q32 + (64'd1 << (31 - FRACTION_BITS))) >> (32 - FRACTION_BITS);
	localparam logic [FRACTION_BITS-1:0] ROT_COEF = ROT_COEF_FULL[FRACTION_BITS-1:0];

	// Division of a 16-bit magnitude by 327 as a multiply by a scaled
	// reciprocal; exact for every magnitude up to 32768.
	localparam int unsigned   DIV_SHIFT = 23;
	localparam logic [14:0]   DIV_RECIP = 15'd25654;

	// Event type codes and the init flag position.
	localparam logic [7:0] EV_BUTTON = 8'd1;
	localparam logic [7:0] EV_AXIS   = 8'd2;
	localparam int unsigned EV_INIT_BIT = 7;

	typedef enum logic [2:0] {
		REG_LEFT_X_AXIS  = 3'd0,
		REG_LEFT_Y_AXIS  = 3'd1,
		REG_RIGHT_X_AXIS = 3'd2,
		REG_STOP_BUTTON  = 3'd3,
		REG_AXIS_COUNT   = 3'd4,
		REG_BUTTON_COUNT = 3'd5,
		REG_DEADBAND     = 3'd6,
		REG_PWM_RANGE    = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] left_x_axis;
		logic [7:0] left_y_axis;
		logic [7:0] right_x_axis;
		logic [7:0] stop_button;
		logic [7:0] axis_count;
		logic [7:0] button_count;
		logic [6:0] deadband;
		logic [6:0] pwm_range;
	} cfg_t;

	// Stick values and stop flag as they stand after one event.
	typedef struct packed {
		logic signed [7:0] left_x;
		logic signed [7:0] left_y;
		logic signed [7:0] right_x;
		logic              stop;
	} sticks_t;

	typedef struct packed {
		logic [6:0] neg;
		logic [6:0] pos;
	} hbridge_t;

	// Signed value times sqrt(1/2), truncated toward zero.
	function automatic logic signed [8:0] rotate45(input logic signed [8:0] d);
		logic [7:0]                   mag;
		logic [FRACTION_BITS+7:0]     prod;
		logic [7:0]                   r;
		mag  = d[8] ? 8'(-d) : d[7:0];
		prod = (FRACTION_BITS+8)'(mag) * (FRACTION_BITS+8)'(ROT_COEF);
		r    = prod[FRACTION_BITS+7:FRACTION_BITS];
		return d[8] ? -$signed({1'b0, r}) : $signed({1'b0, r});
	endfunction

	// Deadband, saturation and direction select for one H-bridge.
	function automatic hbridge_t drive_motor(input logic signed [8:0] v,
			input logic [6:0] deadband, input logic [6:0] pwm_range);
		logic [7:0] mag;
		logic [7:0] sat;
		hbridge_t   h;
		mag   = v[8] ? 8'(-v) : v[7:0];
		sat   = (mag > {1'b0, pwm_range}) ? {1'b0, pwm_range} : mag;
		h.neg = 7'd0;
		h.pos = 7'd0;
		if (mag >= {1'b0, deadband}) begin
			if (v > 9'sd0) begin
				h.pos = sat[6:0];
			end else begin
				h.neg = sat[6:0];
			end
		end
		return h;
	endfunction

endpackage

>>> sv/jomm_cfg.sv
// ----------------------------------------------------------------------------
// jomm_cfg
// Configuration register file of the joystick motor mixer.
// ----------------------------------------------------------------------------
module jomm_cfg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [7:0]       cfg_data,
	output jomm_pkg::cfg_t   cfg
);
	import jomm_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left_x_axis  <= 8'd0;
			cfg_q.left_y_axis  <= 8'd1;
			cfg_q.right_x_axis <= 8'd2;
			cfg_q.stop_button  <= 8'd14;
			cfg_q.axis_count   <= 8'd27;
			cfg_q.button_count <= 8'd19;
			cfg_q.deadband     <= 7'd5;
			cfg_q.pwm_range    <= 7'd20;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LEFT_X_AXIS:  cfg_q.left_x_axis  <= cfg_data;
				REG_LEFT_Y_AXIS:  cfg_q.left_y_axis  <= cfg_data;
				REG_RIGHT_X_AXIS: cfg_q.right_x_axis <= cfg_data;
				REG_STOP_BUTTON:  cfg_q.stop_button  <= cfg_data;
				REG_AXIS_COUNT:   cfg_q.axis_count   <= cfg_data;
				REG_BUTTON_COUNT: cfg_q.button_count <= cfg_data;
				REG_DEADBAND:     cfg_q.deadband     <= cfg_data[6:0];
				REG_PWM_RANGE:    cfg_q.pwm_range    <= cfg_data[6:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> sv/jomm_event.sv
// ----------------------------------------------------------------------------
// jomm_event
// Input register, axis scaling and stick state update. Passes a snapshot of
// the stick state after each event without the init flag to the mixing stage.
// ----------------------------------------------------------------------------
module jomm_event (
	input  logic              clk,
	input  logic              arst_n,
	input  jomm_pkg::cfg_t    cfg,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        req_type,
	input  logic [7:0]        event_number,
	input  logic signed [15:0] event_value,
	output logic              snap_valid,
	input  logic              snap_ready,
	output jomm_pkg::sticks_t snap
);
	import jomm_pkg::*;

	logic              valid_s1;
	logic [7:0]        type_s1;
	logic [7:0]        num_s1;
	logic signed [15:0] val_s1;

	logic              valid_s2;
	sticks_t           sticks_s2;
	sticks_t           state_q;
	sticks_t           state_next;

	logic              en_s1;
	logic              en_s2;
	logic [15:0]       val_mag;
	logic [30:0]       quot_prod;
	logic [7:0]        quot;
	logic signed [7:0] scaled;
	logic              axis_hit;

	assign en_s2    = !valid_s2 || snap_ready;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_stall = !en_s1;

	// Init events are swallowed here; every beat that reaches stage one
	// produces a result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= in_valid && !req_type[EV_INIT_BIT];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			type_s1 <= req_type;
			num_s1  <= event_number;
			val_s1  <= event_value;
		end
	end

	always_comb begin
		val_mag   = val_s1[15] ? 16'(-val_s1) : val_s1;
		quot_prod = 31'(val_mag) * 31'(DIV_RECIP);
		quot      = quot_prod[30:DIV_SHIFT];
		scaled    = val_s1[15] ? -$signed(quot) : $signed(quot);
		axis_hit  = (type_s1 == EV_AXIS) && (num_s1 < cfg.axis_count);

		state_next = state_q;
		if (axis_hit && num_s1 == cfg.left_x_axis) begin
			state_next.left_x = scaled;
		end
		if (axis_hit && num_s1 == cfg.left_y_axis) begin
			state_next.left_y = scaled;
		end
		if (axis_hit && num_s1 == cfg.right_x_axis) begin
			state_next.right_x = scaled;
		end
		if (type_s1 == EV_BUTTON && num_s1 < cfg.button_count
				&& num_s1 == cfg.stop_button) begin
			state_next.stop = (val_s1 == 16'sd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			valid_s2 <= 1'b0;
		end else if (en_s2) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				state_q <= state_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			sticks_s2 <= state_next;
		end
	end

	assign snap_valid = valid_s2;
	assign snap       = sticks_s2;

endmodule

>>> sv/jomm_mix.sv
// ----------------------------------------------------------------------------
// jomm_mix
// 45 degree rotation of the left stick, H-bridge drive mapping for all four
// motors and the result register.
// ----------------------------------------------------------------------------
module jomm_mix (
	input  logic              clk,
	input  logic              arst_n,
	input  jomm_pkg::cfg_t    cfg,
	input  logic              snap_valid,
	output logic              snap_ready,
	input  jomm_pkg::sticks_t snap,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [6:0]        motor1_rev,
	output logic [6:0]        motor1_fwd,
	output logic [6:0]        motor2_rev,
	output logic [6:0]        motor2_fwd,
	output logic [6:0]        motor3_rev,
	output logic [6:0]        motor3_fwd,
	output logic [6:0]        motor4_fwd,
	output logic [6:0]        motor4_rev,
	output logic              stop_request
);
	import jomm_pkg::*;

	logic              out_valid_q;
	logic              en_out;
	logic signed [8:0] lx;
	logic signed [8:0] ly;
	logic signed [8:0] rot_x;
	logic signed [8:0] rot_y;
	hbridge_t          m1;
	hbridge_t          m2;
	hbridge_t          m34;
	hbridge_t          m1_q;
	hbridge_t          m2_q;
	hbridge_t          m34_q;
	logic              stop_q;

	assign en_out     = !out_valid_q || !out_stall;
	assign snap_ready = en_out;

	always_comb begin
		lx    = 9'(snap.left_x);
		ly    = 9'(snap.left_y);
		rot_x = rotate45(ly - lx);
		rot_y = rotate45(lx + ly);
		m1    = drive_motor(rot_y, cfg.deadband, cfg.pwm_range);
		m2    = drive_motor(rot_x, cfg.deadband, cfg.pwm_range);
		m34   = drive_motor(9'(snap.right_x), cfg.deadband, cfg.pwm_range);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= snap_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && snap_valid) begin
			m1_q   <= m1;
			m2_q   <= m2;
			m34_q  <= m34;
			stop_q <= snap.stop;
		end
	end

	// Motor four is driven in the same sense as motor three, from the same values.
	assign out_valid    = out_valid_q;
	assign motor1_rev   = m1_q.neg;
	assign motor1_fwd   = m1_q.pos;
	assign motor2_rev   = m2_q.neg;
	assign motor2_fwd   = m2_q.pos;
	assign motor3_rev   = m34_q.neg;
	assign motor3_fwd   = m34_q.pos;
	assign motor4_fwd   = m34_q.pos;
	assign motor4_rev   = m34_q.neg;
	assign stop_request = stop_q;

endmodule

>>> sv/joystick_omni_motor_mixer.sv
// ----------------------------------------------------------------------------
// joystick_omni_motor_mixer
// Joystick event to H-bridge duty mixer for a four-motor omni base.
// ----------------------------------------------------------------------------
// The block accepts one joystick event beat per clock cycle while in_stall is
// low and returns one result beat, the eight H-bridge duty values and the
// stop flag, for every event without the init flag; init events are dropped.
// An event beat passes the input register, after which the axis value is
// scaled and the stick state updated, then the snapshot register, then the
// rotation and drive logic ahead of the result register. Each stage holds
// its beat only while the stage after it is stalled, so a waiting result
// stalls new events only once all three stages hold beats.
module joystick_omni_motor_mixer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [7:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         req_type,
	input  logic [7:0]         event_number,
	input  logic signed [15:0] event_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [6:0]         motor1_rev,
	output logic [6:0]         motor1_fwd,
	output logic [6:0]         motor2_rev,
	output logic [6:0]         motor2_fwd,
	output logic [6:0]         motor3_rev,
	output logic [6:0]         motor3_fwd,
	output logic [6:0]         motor4_fwd,
	output logic [6:0]         motor4_rev,
	output logic               stop_request
);
	import jomm_pkg::*;

	cfg_t    cfg;
	sticks_t snap;
	logic    snap_valid;
	logic    snap_ready;

	jomm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	jomm_event u_event (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.event_number (event_number),
		.event_value  (event_value),
		.snap_valid   (snap_valid),
		.snap_ready   (snap_ready),
		.snap         (snap)
	);

	jomm_mix u_mix (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.snap_valid   (snap_valid),
		.snap_ready   (snap_ready),
		.snap         (snap),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.motor1_rev   (motor1_rev),
		.motor1_fwd   (motor1_fwd),
		.motor2_rev   (motor2_rev),
		.motor2_fwd   (motor2_fwd),
		.motor3_rev   (motor3_rev),
		.motor3_fwd   (motor3_fwd),
		.motor4_fwd   (motor4_fwd),
		.motor4_rev   (motor4_rev),
		.stop_request (stop_request)
	);

endmodule
